@@ src/softmax_vector_normalizer_macros.svh @@
// assertion helpers, included by sfx_ctrl
`ifndef SOFTMAX_VECTOR_NORMALIZER_MACROS_SVH
`define SOFTMAX_VECTOR_NORMALIZER_MACROS_SVH

// condition must hold at every edge out of reset
`define SFX_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sfx_pkg.sv @@
// ----------------------------------------------------------------------------
// sfx_pkg
// shared constants, command struct and the exp2 fraction table
// ----------------------------------------------------------------------------
`default_nettype none

package sfx_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned DIV_STEPS   = 17;
  localparam logic [32:0] LOG2E_Q16   = 33'd94548;
  localparam logic [32:0] ROUND_HALF  = 33'd32768;

  // datapath commands from the controller
  typedef struct packed {
    logic clear;
    logic first;
    logic load_wr;
    logic rd_score;
    logic mul_en;
    logic exp_wr;
    logic rd_exp;
    logic div_init;
    logic div_step;
  } sfx_cmd_t;

  typedef logic [255:0][16:0] sfx_rom_t;

  // integer square root, used only while building the table
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-f/256) in q1.16 from a chain of square-root factors
  function automatic sfx_rom_t build_exp2_rom();
    sfx_rom_t    rom;
    logic [63:0] factor [8];
    logic [63:0] acc;
    factor[7] = isqrt64(64'd1 << 63);
    for (int k = 7; k > 0; k--) factor[k-1] = isqrt64(factor[k] << 32);
    for (int f = 0; f < 256; f++) begin
      acc = 64'd1 << 32;
      for (int k = 0; k < 8; k++) begin
        if (((f >> k) & 1) != 0) acc = (acc * factor[k] + (64'd1 << 31)) >> 32;
      end
      rom[f] = 17'((acc + 64'd32768) >> 16);
    end
    return rom;
  endfunction

  localparam sfx_rom_t EXP2_ROM = build_exp2_rom();

endpackage

`default_nettype wire

@@ src/sfx_dpath.sv @@
// ----------------------------------------------------------------------------
// sfx_dpath
// score and exp stores, max tracking, exp unit, sum and serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_dpath import sfx_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF,
  parameter int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sfx_cmd_t      cmd_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [15:0]   score_i,
  output logic [15:0]        probability_o
);

  logic [15:0] score_mem [MAX_LEN];
  logic [16:0] exp_mem   [MAX_LEN];
  logic [15:0] score_rd_q;
  logic [16:0] exp_rd_q;
  logic [15:0] max_q, max_d;
  logic [22:0] sum_q, sum_d;
  logic [32:0] prod_q;
  logic [23:0] rem_q;
  logic [16:0] quo_q;
  logic [15:0] diff;
  logic [16:0] y;
  logic [16:0] exp_val;

  // stores, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) score_mem[addr_i] <= score_i;
    if (cmd_i.rd_score) score_rd_q <= score_mem[addr_i];
    if (cmd_i.exp_wr) exp_mem[addr_i] <= exp_val;
    if (cmd_i.rd_exp) exp_rd_q <= exp_mem[addr_i];
  end

  // exp of (max - score): multiply, then table lookup and shift
  assign diff = max_q - score_rd_q;
  assign y    = prod_q[32:16];
  always_comb begin
    if (y[16:8] > 9'd16) exp_val = '0;
    else exp_val = EXP2_ROM[y[7:0]] >> y[4+8:8];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= 33'(diff) * LOG2E_Q16 + ROUND_HALF;
  end

  // running max and sum
  always_comb begin
    max_d = max_q;
    sum_d = sum_q;
    if (cmd_i.clear) begin
      max_d = 16'h8000;
      sum_d = '0;
    end else begin
      if (cmd_i.load_wr && (cmd_i.first || $signed(score_i) > $signed(max_q))) max_d = score_i;
      if (cmd_i.exp_wr) sum_d = sum_q + 23'(exp_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'h8000;
      sum_q <= '0;
    end else begin
      max_q <= max_d;
      sum_q <= sum_d;
    end
  end

  // restoring divider, one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= 24'(exp_rd_q);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= 24'(sum_q)) begin
        rem_q <= (rem_q - 24'(sum_q)) << 1;
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= rem_q << 1;
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
  end

  // saturate and guard empty sum
  always_comb begin
    if (sum_q == '0) probability_o = '0;
    else if (quo_q[16]) probability_o = 16'hFFFF;
    else probability_o = quo_q[15:0];
  end

endmodule

`default_nettype wire

@@ src/sfx_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfx_ctrl
// sequencer for load, exp pass, divide pass and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_ctrl import sfx_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF,
  parameter int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  parameter int unsigned CW      = $clog2(MAX_LEN + 1)
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  input  wire logic   in_last_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output logic        out_last_o,
  input  wire logic   out_ready_i,
  output sfx_cmd_t    cmd_o,
  output logic [AW-1:0] addr_o
);

  typedef enum logic [2:0] {
    LOAD, EXP_RD, EXP_MUL, EXP_WR, DIV_RD, DIV_INIT, DIV_STEP, OUT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [4:0]    step_q, step_d;
  logic          in_beat, out_beat, idx_last, room;

  assign in_ready_o  = (state_q == LOAD);
  assign out_valid_o = (state_q == OUT);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_beat    = out_valid_o && out_ready_i;
  assign idx_last    = (CW'(idx_q) + CW'(1)) == count_q;
  assign room        = count_q < CW'(MAX_LEN);
  assign out_last_o  = idx_last;
  assign addr_o      = (state_q == LOAD) ? count_q[AW-1:0] : idx_q;

  // commands and next state
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      LOAD: begin
        cmd_o.first = (count_q == '0);
        if (in_beat) begin
          if (room) begin
            cmd_o.load_wr = 1'b1;
            count_d = count_q + CW'(1);
          end
          if (in_last_i) begin
            idx_d   = '0;
            state_d = EXP_RD;
          end
        end
      end
      EXP_RD: begin
        cmd_o.rd_score = 1'b1;
        state_d = EXP_MUL;
      end
      EXP_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = EXP_WR;
      end
      EXP_WR: begin
        cmd_o.exp_wr = 1'b1;
        if (idx_last) begin
          idx_d   = '0;
          state_d = DIV_RD;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = EXP_RD;
        end
      end
      DIV_RD: begin
        cmd_o.rd_exp = 1'b1;
        state_d = DIV_INIT;
      end
      DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d  = '0;
        state_d = DIV_STEP;
      end
      DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 5'd1;
        if (step_q == 5'(DIV_STEPS - 1)) state_d = OUT;
      end
      OUT: begin
        if (out_beat) begin
          if (idx_last) begin
            cmd_o.clear = 1'b1;
            count_d = '0;
            idx_d   = '0;
            state_d = LOAD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = DIV_RD;
          end
        end
      end
      default: state_d = LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LOAD;
      count_q <= '0;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

`include "softmax_vector_normalizer_macros.svh"

  `SFX_ASSERT_ALWAYS(a_one_side, !(in_ready_o && out_valid_o), "both sides open")
  `SFX_ASSERT_ALWAYS(a_count_cap, count_q <= CW'(MAX_LEN), "count beyond capacity")
  `SFX_ASSERT_ALWAYS(a_idx_range, (state_q == LOAD) || (CW'(idx_q) < count_q), "index out of range")
  `SFX_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i, $stable(idx_q) && out_valid_o, "stalled result moved")

endmodule

`default_nettype wire

@@ src/softmax_vector_normalizer.sv @@
// ----------------------------------------------------------------------------
// softmax_vector_normalizer
// softmax with max subtraction over a stored vector of q8.8 scores
// ----------------------------------------------------------------------------
// channel  dir  tdata                  tlast
// s_axis   in   [15:0] score (signed)  last_element
// m_axis   out  [15:0] probability     last_result
//
// load takes one beat per cycle; the last beat starts the exp pass.
// exp pass: per element a store read, a multiply, then table and sum.
// divide pass: per element a read, an init and 17 divider steps, then the
// output beat, held while m_axis_tready is low.
// reset clears the sequencer, count, max and sum; the stores need no clearing.
`default_nettype none

module softmax_vector_normalizer import sfx_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] score
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] probability
  output logic             m_axis_tlast
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  sfx_cmd_t      cmd;
  logic [AW-1:0] addr;

  // sequencer
  sfx_ctrl #(.MAX_LEN(MAX_LEN), .AW(AW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  // arithmetic and stores
  sfx_dpath #(.MAX_LEN(MAX_LEN), .AW(AW)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .addr_i        (addr),
    .score_i       (s_axis_tdata),
    .probability_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the softmax normalizer: directed vectors, then random
// vectors with random gaps on both sides, checked against a local predictor
// ----------------------------------------------------------------------------
`default_nettype none

// holds expected probabilities per vector and compares output beats
class softmax_scoreboard;
  logic [16:0] exp2_tab [256];
  logic [15:0] held_scores [$];
  logic [16:0] pending_prob [$];
  int errors;
  int beats_in;
  int beats_out;
  int vectors;

  function new();
    logic [63:0] fac [8];
    logic [63:0] acc;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    vectors = 0;
    fac[7] = int_sqrt(64'd1 << 63);
    for (int k = 7; k > 0; k--) fac[k-1] = int_sqrt(fac[k] << 32);
    for (int f = 0; f < 256; f++) begin
      acc = 64'd1 << 32;
      for (int k = 0; k < 8; k++)
        if (f[k]) acc = (acc * fac[k] + (64'd1 << 31)) >> 32;
      exp2_tab[f] = 17'((acc + 64'd32768) >> 16);
    end
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exp(-e) in q1.16 via 2^(-e*log2e)
  function logic [16:0] exp_neg(logic [15:0] e);
    logic [63:0] y;
    y = (64'(e) * 64'd94548 + 64'd32768) >> 16;
    if ((y >> 8) > 16) return 17'd0;
    return exp2_tab[y[7:0]] >> (y >> 8);
  endfunction

  // store one input beat; on the last one build the expected probabilities
  function void note_score(logic [15:0] score, logic last);
    logic signed [15:0] peak;
    logic [16:0] ex [$];
    logic [22:0] total;
    logic [63:0] p;
    beats_in++;
    if (held_scores.size() < 64) held_scores.push_back(score);
    if (!last) return;
    vectors++;
    peak = $signed(held_scores[0]);
    foreach (held_scores[i])
      if ($signed(held_scores[i]) > peak) peak = $signed(held_scores[i]);
    total = 0;
    foreach (held_scores[i]) begin
      ex.push_back(exp_neg(16'(peak - $signed(held_scores[i]))));
      total = total + 23'(ex[i]);
    end
    foreach (ex[i]) begin
      p = 0;
      if (total != 0) begin
        p = (64'(ex[i]) << 16) / 64'(total);
        if (p > 65535) p = 65535;
      end
      pending_prob.push_back({(i == ex.size() - 1) ? 1'b1 : 1'b0, p[15:0]});
    end
    held_scores.delete();
  endfunction

  function void check_prob(logic [15:0] prob, logic last);
    logic [16:0] want;
    beats_out++;
    if (pending_prob.size() == 0) begin
      $display("%0t: unexpected beat prob=%0d last=%0b", $time, prob, last);
      errors++;
      return;
    end
    want = pending_prob.pop_front();
    if (want[15:0] !== prob) begin
      $display("%0t: probability exp=%0d act=%0d", $time, want[15:0], prob);
      errors++;
    end
    if (want[16] !== last) begin
      $display("%0t: tlast exp=%0b act=%0b", $time, want[16], last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  softmax_scoreboard sb = new();
  int idle_cycles = 0;
  bit out_idle_free = 0;

  softmax_vector_normalizer DUT (.*);

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // one input beat with a random lead-in gap; valid stays up between
  // back-to-back beats
  task automatic send_score(logic [15:0] score, logic last);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= score;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_score(score, last);
    @(negedge clk_i);
  endtask

  task automatic send_vector(int len, int mode);
    logic [15:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = 16'($urandom);
        1: s = 16'($urandom_range(0, 2047) - 1024);
        default: s = 16'($urandom_range(0, 255) + 16'h0100 * $urandom_range(0, 3));
      endcase
      send_score(s, i == len - 1);
    end
  endtask

  // output side: random stalls, sometimes none
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = out_idle_free ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_prob(m_axis_tdata, m_axis_tlast);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: single elements at the extremes
    send_score(16'h7fff, 1'b1);
    send_score(16'h8000, 1'b1);
    send_score(16'h0000, 1'b1);
    // deep negative differences give zero
    send_score(16'h7fff, 1'b0);
    send_score(16'h8000, 1'b0);
    send_score(16'hffff, 1'b0);
    send_score(16'h0001, 1'b1);
    // equal scores and a tied max
    send_score(16'h0100, 1'b0);
    send_score(16'h0100, 1'b1);
    // overlong vector: 70 elements, those beyond the first 64 dropped
    for (int i = 0; i < 70; i++) send_score(16'($urandom_range(0, 1023)), i == 69);
    // random vectors, mostly short
    while (sb.beats_in < 310) begin
      out_idle_free = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 8);
      send_vector(len, $urandom_range(0, 2));
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending_prob.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d input beats in %0d vectors, %0d output beats",
             sb.beats_in, sb.vectors, sb.beats_out);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
